### rtl/core/bab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_pkg
// shared types, constants and helpers of the alpha blit unit
// ----------------------------------------------------------------------------
package bab_pkg;

  localparam int DEST_PIXELS = 65536;
  localparam int ADDR_W      = $clog2(DEST_PIXELS);
  localparam int MAX_DIM     = 4096;
  localparam int DIM_W       = 13;
  localparam int CNT_W       = 12;
  localparam int COORD_W     = 16;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;
  localparam int IDX_W       = 2 * DIM_W + 1;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'h00;

  typedef enum logic [2:0] {
    REG_BPP_MODE     = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_ORIGIN_X     = 3'd3,
    REG_ORIGIN_Y     = 3'd4,
    REG_DEST_WIDTH   = 3'd5,
    REG_DEST_HEIGHT  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                      bpp_mode;
    logic [DIM_W-1:0]          image_width;
    logic [DIM_W-1:0]          image_height;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [DIM_W-1:0]          dest_width;
    logic [DIM_W-1:0]          dest_height;
  } cfg_t;

  // placed pixel, ready for the read-modify-write
  typedef struct packed {
    logic              go;
    logic              opaque;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   alpha;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } item_t;

  typedef struct packed {
    logic              written;
    logic              blended;
    logic [ADDR_W-1:0] address;
    logic [PIX_W-1:0]  pixel;
    logic              last;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // (s*a + bg*(255-a)) / 255, truncated; divide by 255 via (x + 1 + x>>8) >> 8
  function automatic logic [CH_W-1:0] mix8(input logic [CH_W-1:0] s,
                                           input logic [CH_W-1:0] bg,
                                           input logic [CH_W-1:0] a);
    logic [2*CH_W:0] x;
    logic [2*CH_W:0] q;
    x = (2*CH_W+1)'(s) * (2*CH_W+1)'(a) +
        (2*CH_W+1)'(bg) * (2*CH_W+1)'(ALPHA_OPAQUE - a);
    q = (x + (2*CH_W+1)'(1) + (x >> CH_W)) >> CH_W;
    return q[CH_W-1:0];
  endfunction

endpackage

### rtl/core/bmp_alpha_blit_clipped_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_alpha_blit_clipped_unit
// alpha-blending blit of a bottom-up bitmap into a clipped pixel store
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one source pixel per transfer,
//   in stored bitmap order, bottom row first, restart marking an image start.
//   output channel (out_valid/out_ready) returns one result per pixel:
//   written/blended flags, store address, written color and the last flag.
//   an apb port sets format, image size, origin and destination size; write
//   it only while no pixel is in flight.
// throughput: one pixel per cycle sustained while the output buffer has room. the limit is the
//   single read-modify-write port of the destination store, kept in step by a
//   one-entry forward register for back-to-back hits on the same word.
// path: an input transfer is registered after the clip, after the index multiply,
//   after the store read and after blend/write-back, where the output buffer takes it.
// reset: clears registers, then sweeps the 65536-word store to zero, one
//   word per cycle; in_ready stays low until the sweep ends.
// stall: a two-entry output buffer keeps taking pixels while one result
//   waits; once both entries are full the whole pipeline holds.
// ----------------------------------------------------------------------------
module bmp_alpha_blit_clipped_unit import bab_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // apb configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // pixel input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CH_W-1:0]    blue,
  input  logic [CH_W-1:0]    green,
  input  logic [CH_W-1:0]    red,
  input  logic [CH_W-1:0]    alpha,
  input  logic               restart,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               written,
  output logic               blended,
  output logic [ADDR_W-1:0]  address,
  output logic [PIX_W-1:0]   pixel,
  output logic               last
);

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  logic     en, take, clear_busy;
  logic     s2_valid, s3_valid;
  item_t    s2;
  result_t  res, out_res;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bpp_mode     <= 1'b1;
      cfg.image_width  <= DIM_W'(1);
      cfg.image_height <= DIM_W'(1);
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.dest_width   <= DIM_W'(256);
      cfg.dest_height  <= DIM_W'(256);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BPP_MODE:     cfg.bpp_mode     <= pwdata[0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[DIM_W-1:0];
        REG_ORIGIN_X:     cfg.origin_x     <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y     <= pwdata[COORD_W-1:0];
        REG_DEST_WIDTH:   cfg.dest_width   <= pwdata[DIM_W-1:0];
        REG_DEST_HEIGHT:  cfg.dest_height  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back, signed origins sign extended
  always_comb begin
    unique case (reg_sel)
      REG_BPP_MODE:     prdata = PDATA_W'(cfg.bpp_mode);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(cfg.image_height);
      REG_ORIGIN_X:     prdata = {{(PDATA_W-COORD_W){cfg.origin_x[COORD_W-1]}}, cfg.origin_x};
      REG_ORIGIN_Y:     prdata = {{(PDATA_W-COORD_W){cfg.origin_y[COORD_W-1]}}, cfg.origin_y};
      REG_DEST_WIDTH:   prdata = PDATA_W'(cfg.dest_width);
      REG_DEST_HEIGHT:  prdata = PDATA_W'(cfg.dest_height);
      default:          prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  // en advances every stage together; it drops only when the output buffer is full
  assign in_ready = en && !clear_busy;
  assign take     = in_valid && in_ready;

  bab_place u_place (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .en       (en),
    .take     (take),
    .blue     (blue),
    .green    (green),
    .red      (red),
    .alpha    (alpha),
    .restart  (restart),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  bab_blend u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .s3_valid   (s3_valid),
    .res        (res),
    .clear_busy (clear_busy)
  );

  bab_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (s3_valid && en),
    .push_data (res),
    .out_ready (out_ready),
    .room      (en),
    .out_valid (out_valid),
    .out_data  (out_res)
  );

  assign written = out_res.written;
  assign blended = out_res.blended;
  assign address = out_res.address;
  assign pixel   = out_res.pixel;
  assign last    = out_res.last;

endmodule

### rtl/core/bab_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_place
// position counters, key, clip window and destination index
// ----------------------------------------------------------------------------
module bab_place import bab_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            en,
  input  logic            take,
  input  logic [CH_W-1:0] blue,
  input  logic [CH_W-1:0] green,
  input  logic [CH_W-1:0] red,
  input  logic [CH_W-1:0] alpha,
  input  logic            restart,
  output logic            s2_valid,
  output item_t           s2
);

  logic [CNT_W-1:0] column_count, stored_row_count;
  logic [CNT_W-1:0] col, row;
  logic [DIM_W-1:0] w, h;
  logic [CH_W-1:0]  a_eff;
  logic [17:0]      dx, dy;
  logic             in_win, row_end, img_end;

  // stage 1 registers
  logic             s1_valid, s1_go, s1_opaque, s1_last;
  logic [DIM_W-1:0] s1_dx, s1_dy;
  logic [CH_W-1:0]  s1_red, s1_green, s1_blue, s1_alpha;

  logic [2*DIM_W-1:0] prod;
  logic [IDX_W-1:0]   idx_full;

  always_comb begin
    col   = restart ? '0 : column_count;
    row   = restart ? '0 : stored_row_count;
    w     = clamp_dim(cfg.image_width);
    h     = clamp_dim(cfg.image_height);
    if (!cfg.bpp_mode) begin
      a_eff = (red == ALPHA_OPAQUE && green == '0 && blue == ALPHA_OPAQUE) ?
              ALPHA_CLEAR : ALPHA_OPAQUE;
    end else begin
      a_eff = alpha;
    end
    dx = {{2{cfg.origin_x[COORD_W-1]}}, cfg.origin_x} + 18'(col);
    dy = {{2{cfg.origin_y[COORD_W-1]}}, cfg.origin_y} + 18'(h) - 18'd1 - 18'(row);
    in_win = !dx[17] && !dy[17] && dx < 18'(cfg.dest_width) && dy < 18'(cfg.dest_height);
    row_end = (DIM_W'(col) + DIM_W'(1)) >= w;
    img_end = row_end && ((DIM_W'(row) + DIM_W'(1)) >= h);
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      stored_row_count <= '0;
    end else if (take) begin
      if (img_end) begin
        column_count     <= '0;
        stored_row_count <= '0;
      end else if (row_end) begin
        column_count     <= '0;
        stored_row_count <= row + CNT_W'(1);
      end else begin
        column_count     <= col + CNT_W'(1);
        stored_row_count <= row;
      end
    end
  end

  // destination index, one multiply
  assign prod     = s1_dy * cfg.dest_width;
  assign idx_full = IDX_W'(prod) + IDX_W'(s1_dx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_go     <= (a_eff != ALPHA_CLEAR) && in_win;
      s1_opaque <= a_eff == ALPHA_OPAQUE;
      s1_last   <= img_end;
      s1_dx     <= dx[DIM_W-1:0];
      s1_dy     <= dy[DIM_W-1:0];
      s1_red    <= red;
      s1_green  <= green;
      s1_blue   <= blue;
      s1_alpha  <= a_eff;

      s2.go     <= s1_go && (idx_full < IDX_W'(DEST_PIXELS));
      s2.opaque <= s1_opaque;
      s2.red    <= s1_red;
      s2.green  <= s1_green;
      s2.blue   <= s1_blue;
      s2.alpha  <= s1_alpha;
      s2.last   <= s1_last;
      s2.idx    <= idx_full[ADDR_W-1:0];
    end
  end

endmodule

### rtl/core/bab_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_blend
// destination store with clearing pass, read-modify-write and forwarding
// ----------------------------------------------------------------------------
module bab_blend import bab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    s2_valid,
  input  item_t   s2,
  output logic    s3_valid,
  output result_t res,
  output logic    clear_busy
);

  logic [PIX_W-1:0]  mem [DEST_PIXELS];
  logic [PIX_W-1:0]  rd_data;
  item_t             s3;
  logic [ADDR_W-1:0] clear_addr;

  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_idx;
  logic [PIX_W-1:0]  fwd_data;

  logic [PIX_W-1:0]  bg, pix;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;

  // a write from the item just ahead is not yet in the read data
  assign bg = (fwd_valid && fwd_idx == s3.idx) ? fwd_data : rd_data;

  always_comb begin
    if (s3.opaque) begin
      pix = {s3.red, s3.green, s3.blue};
    end else begin
      pix = {mix8(s3.red,   bg[23:16], s3.alpha),
             mix8(s3.green, bg[15:8],  s3.alpha),
             mix8(s3.blue,  bg[7:0],   s3.alpha)};
    end
    res.written = s3.go;
    res.blended = s3.go && !s3.opaque;
    res.address = s3.go ? s3.idx : '0;
    res.pixel   = s3.go ? pix : '0;
    res.last    = s3.last;
  end

  assign mem_we    = clear_busy || (en && s3_valid && s3.go);
  assign mem_waddr = clear_busy ? clear_addr : s3.idx;
  assign mem_wdata = clear_busy ? '0 : pix;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (en) begin
      rd_data <= mem[s2.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
      s3_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
    end else begin
      if (clear_busy) begin
        clear_addr <= clear_addr + ADDR_W'(1);
        if (clear_addr == '1) begin
          clear_busy <= 1'b0;
        end
      end
      if (en) begin
        s3_valid  <= s2_valid;
        fwd_valid <= s3_valid && s3.go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3       <= s2;
      fwd_idx  <= s3.idx;
      fwd_data <= pix;
    end
  end

  a_idle_in_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !s2_valid && !s3_valid)
    else $error("pixel in flight during clearing pass");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (rst)
    (en && s3_valid && s3.go && !clear_busy) |=> fwd_valid && fwd_idx == $past(s3.idx))
    else $error("forward register missed a store write");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clear_busy) |-> $past(clear_addr) == '1)
    else $error("clearing pass ended early");

endmodule

### rtl/core/bab_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bab_out_buf
// two-entry result buffer between pipeline and receiver
// ----------------------------------------------------------------------------
module bab_out_buf import bab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    out_ready,
  output logic    room,
  output logic    out_valid,
  output result_t out_data
);

  result_t    buf_q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign room      = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = buf_q[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
